[rtl/mrec_pkg.sv]
// Package for the motion repetition error classifier.
// Holds the register indexes, reset values, field widths and result codes.
// No dependencies.
package mrec_pkg;

    // Field widths.
    localparam int TICK_W      = 32;
    localparam int ANGLE_IN_W  = 15;
    localparam int LIMIT_W     = 14;
    localparam int RATE_W      = 16;
    localparam int GAP_W       = 10;
    localparam int CODE_W      = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Default width of the stored angle state.
    localparam int ANGLE_WIDTH_DEF = 16;

    // Milliseconds per second, scales the pitch step in the tempo test.
    localparam int TEMPO_SCALE = 1000;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_MIN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROLL_MAX       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_MAX       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_MIN       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DESCENT_MARGIN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_MAX_MS     = 3'd5;

    // Register reset values.
    localparam logic [LIMIT_W-1:0] ACTIVE_MIN_RST     = 14'd768;
    localparam logic [LIMIT_W-1:0] ROLL_MAX_RST       = 14'd1600;
    localparam logic [RATE_W-1:0]  RATE_MAX_RST       = 16'd7040;
    localparam logic [LIMIT_W-1:0] PEAK_MIN_RST       = 14'd2880;
    localparam logic [LIMIT_W-1:0] DESCENT_MARGIN_RST = 14'd640;
    localparam logic [GAP_W-1:0]   GAP_MAX_MS_RST     = 10'd200;

    // Result codes.
    typedef enum logic [CODE_W-1:0] {
        ERR_CLEAR         = 3'd0,
        ERR_RUSHED        = 3'd1,
        ERR_SHRUG         = 3'd2,
        ERR_RANGE_LOW     = 3'd3,
        ERR_GENERAL_FORM  = 3'd4
    } err_code_t;

endpackage

[rtl/motion_rep_error_classifier.sv]
// Top level of the motion repetition error classifier.
// Depends on mrec_pkg for widths, register indexes, reset values and codes.
//
// Path: input register, then the classify stage, then the output register, then m_.
// Throughput: one transaction per cycle; the input register, the combinational
//   classify stage (one 16x10 multiply, a constant x1000 scale and compares)
//   and the output register all advance together whenever the output is free.
// Reset: aresetn is synchronous, active low. It empties both pipeline registers,
//   loads the default limits and clears the previous tick, previous pitch and
//   peak pitch.
module motion_rep_error_classifier #(
    parameter int ANGLE_WIDTH = mrec_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Input samples. s_tdata, lowest bit up: tick_ms[31:0], pitch_angle[46:32],
    // roll_angle[61:47], zero pad[63:62].
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,

    // Results. m_tdata, lowest bit up: error_code[2:0], zero pad[7:3].
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,

    // Register writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mrec_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mrec_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mrec_pkg::*;

    // Working width of the angle math: holds a 15 bit sample or a stored
    // angle, plus room for a difference and its magnitude.
    localparam int AW = ANGLE_WIDTH;
    localparam int EW = ((AW > ANGLE_IN_W) ? AW : ANGLE_IN_W) + 2;
    // Width of both sides of the tempo compare.
    localparam int CW = EW + 10;

    // ------------------------------------------------------------------
    // Configuration registers, written any cycle.
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] active_min_reg;
    logic [LIMIT_W-1:0] roll_max_reg;
    logic [RATE_W-1:0]  rate_max_reg;
    logic [LIMIT_W-1:0] peak_min_reg;
    logic [LIMIT_W-1:0] descent_margin_reg;
    logic [GAP_W-1:0]   gap_max_ms_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_min_reg     <= ACTIVE_MIN_RST;
            roll_max_reg       <= ROLL_MAX_RST;
            rate_max_reg       <= RATE_MAX_RST;
            peak_min_reg       <= PEAK_MIN_RST;
            descent_margin_reg <= DESCENT_MARGIN_RST;
            gap_max_ms_reg     <= GAP_MAX_MS_RST;
        end else if (cfg_valid) begin
            // Drop writes to unknown indexes.
            case (cfg_index)
                CFG_ACTIVE_MIN:     active_min_reg     <= cfg_data[LIMIT_W-1:0];
                CFG_ROLL_MAX:       roll_max_reg       <= cfg_data[LIMIT_W-1:0];
                CFG_RATE_MAX:       rate_max_reg       <= cfg_data[RATE_W-1:0];
                CFG_PEAK_MIN:       peak_min_reg       <= cfg_data[LIMIT_W-1:0];
                CFG_DESCENT_MARGIN: descent_margin_reg <= cfg_data[LIMIT_W-1:0];
                CFG_GAP_MAX_MS:     gap_max_ms_reg     <= cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. The output register takes a new result when it is
    // empty or being drained; the input register follows it.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_load;
    logic s1_advance;
    logic in_accept;

    assign out_load   = !m_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && out_load;
    assign s_tready   = !s1_valid_reg || out_load;
    assign in_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Input register: unpack the transaction.
    logic [TICK_W-1:0]            s1_tick_reg;
    logic signed [ANGLE_IN_W-1:0] s1_pitch_reg;
    logic signed [ANGLE_IN_W-1:0] s1_roll_reg;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_tick_reg  <= s_tdata[31:0];
            s1_pitch_reg <= $signed(s_tdata[46:32]);
            s1_roll_reg  <= $signed(s_tdata[61:47]);
        end
    end

    // ------------------------------------------------------------------
    // Sample history.
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]    prev_tick_reg;
    logic signed [AW-1:0] prev_pitch_reg;
    logic signed [AW-1:0] peak_angle_reg;
    logic signed [AW-1:0] peak_angle_next;

    // ------------------------------------------------------------------
    // Classify stage.
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]     dt;
    logic                  time_fault;
    logic signed [EW-1:0]  pitch_ext;
    logic signed [EW-1:0]  prev_ext;
    logic signed [EW-1:0]  peak_ext;
    logic signed [EW-1:0]  pitch_wrap_ext;
    logic signed [EW-1:0]  peak_raised;
    logic signed [EW-1:0]  dpitch;
    logic [EW-1:0]         dpitch_mag;
    logic [EW-1:0]         pitch_mag;
    logic [ANGLE_IN_W:0]   roll_mag;
    logic [CW-1:0]         tempo_lhs;
    logic [CW-1:0]         tempo_rhs;
    logic signed [EW:0]    descent_floor;
    logic                  at_rest;
    logic                  tempo_fast;
    logic                  shoulder_up;
    logic                  descended;
    logic                  peak_short;
    err_code_t             code_next;
    err_code_t             m_code_reg;

    always_comb begin
        dt         = s1_tick_reg - prev_tick_reg;
        time_fault = (prev_tick_reg == '0) || (dt == '0)
                   || (dt > TICK_W'(gap_max_ms_reg));

        pitch_ext = EW'(s1_pitch_reg);
        prev_ext  = EW'(prev_pitch_reg);
        peak_ext  = EW'(peak_angle_reg);

        // Stored pitch is wrapped into the angle state width.
        pitch_wrap_ext = EW'($signed(pitch_ext[AW-1:0]));

        pitch_mag = pitch_ext[EW-1] ? EW'(-pitch_ext) : pitch_ext;
        at_rest   = pitch_mag < EW'(active_min_reg);

        // Raise the peak before any test that reads it.
        peak_raised = (pitch_ext > peak_ext) ? pitch_wrap_ext : peak_ext;

        // Tempo: |dpitch| * 1000 > rate_max * dt, dt known to fit GAP_W here.
        dpitch     = pitch_ext - prev_ext;
        dpitch_mag = dpitch[EW-1] ? EW'(-dpitch) : dpitch;
        tempo_lhs  = CW'(dpitch_mag) * CW'(TEMPO_SCALE);
        tempo_rhs  = CW'(rate_max_reg) * CW'(dt[GAP_W-1:0]);
        tempo_fast = tempo_lhs > tempo_rhs;

        roll_mag    = s1_roll_reg[ANGLE_IN_W-1]
                    ? (ANGLE_IN_W+1)'(-(ANGLE_IN_W+1)'(s1_roll_reg))
                    : (ANGLE_IN_W+1)'(s1_roll_reg);
        shoulder_up = roll_mag > (ANGLE_IN_W+1)'(roll_max_reg);

        descent_floor = (EW+1)'(peak_raised)
                      - (EW+1)'($signed({1'b0, descent_margin_reg}));
        descended     = (EW+1)'(pitch_ext) < descent_floor;
        peak_short    = peak_raised < EW'($signed({1'b0, peak_min_reg}));

        code_next       = ERR_CLEAR;
        peak_angle_next = peak_angle_reg;
        if (time_fault) begin
            // Restart timing; keep the peak.
            code_next = ERR_CLEAR;
        end else if (at_rest) begin
            peak_angle_next = '0;
        end else begin
            peak_angle_next = peak_raised[AW-1:0];
            if (tempo_fast) begin
                code_next = ERR_RUSHED;
            end else if (shoulder_up) begin
                code_next = ERR_SHRUG;
            end else if (descended) begin
                // Repetition finished: judge its peak and start a new one.
                code_next       = peak_short ? ERR_RANGE_LOW : ERR_GENERAL_FORM;
                peak_angle_next = '0;
            end else begin
                code_next = ERR_GENERAL_FORM;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_tick_reg  <= '0;
            prev_pitch_reg <= '0;
            peak_angle_reg <= '0;
        end else if (s1_advance) begin
            prev_tick_reg  <= s1_tick_reg;
            prev_pitch_reg <= pitch_ext[AW-1:0];
            peak_angle_reg <= peak_angle_next;
        end
    end

    // Output register: hold the result until the transaction completes.
    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_code_reg <= code_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - CODE_W){1'b0}}, m_code_reg};

endmodule

[sim/tb_motion_rep_error_classifier.sv]
`timescale 1ns / 100ps
// Self-checking testbench for motion_rep_error_classifier: rep-shaped IMU sample streams
// against an in-bench classifier model, under several limit settings. Depends on mrec_pkg.
module tb_motion_rep_error_classifier;
    import mrec_pkg::*;

    // Scoreboard: tracks the block's state and limits, predicts one code per accepted
    // sample, and checks each result transaction against the oldest pending code.
    class form_scoreboard;
        logic [LIMIT_W-1:0]                   active_min;
        logic [LIMIT_W-1:0]                   roll_max;
        logic [RATE_W-1:0]                    rate_max;
        logic [LIMIT_W-1:0]                   peak_min;
        logic [LIMIT_W-1:0]                   descent_margin;
        logic [GAP_W-1:0]                     gap_max_ms;
        logic [TICK_W-1:0]                    seen_tick;
        logic signed [ANGLE_WIDTH_DEF-1:0]    seen_pitch;
        logic signed [ANGLE_WIDTH_DEF-1:0]    rep_peak;
        err_code_t                            expected_codes[$];
        int                                   code_hits[5];
        int                                   errors;

        function new();
            active_min     = ACTIVE_MIN_RST;
            roll_max       = ROLL_MAX_RST;
            rate_max       = RATE_MAX_RST;
            peak_min       = PEAK_MIN_RST;
            descent_margin = DESCENT_MARGIN_RST;
            gap_max_ms     = GAP_MAX_MS_RST;
            seen_tick      = '0;
            seen_pitch     = '0;
            rep_peak       = '0;
            errors         = 0;
            foreach (code_hits[i]) code_hits[i] = 0;
        endfunction

        function void write_limit(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ACTIVE_MIN:     active_min     = val[LIMIT_W-1:0];
                CFG_ROLL_MAX:       roll_max       = val[LIMIT_W-1:0];
                CFG_RATE_MAX:       rate_max       = val[RATE_W-1:0];
                CFG_PEAK_MIN:       peak_min       = val[LIMIT_W-1:0];
                CFG_DESCENT_MARGIN: descent_margin = val[LIMIT_W-1:0];
                CFG_GAP_MAX_MS:     gap_max_ms     = val[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        function err_code_t classify(logic [TICK_W-1:0] tick,
                                     logic signed [ANGLE_IN_W-1:0] pitch,
                                     logic signed [ANGLE_IN_W-1:0] roll);
            logic [TICK_W-1:0] dt;
            logic [TICK_W-1:0] old_tick;
            longint            p, p_mag, r_mag, old_p, peak, step_mag;
            err_code_t         code;
            dt       = tick - seen_tick;
            old_tick = seen_tick;
            old_p    = longint'(seen_pitch);
            p        = longint'(pitch);
            p_mag    = (p < 0) ? -p : p;
            r_mag    = longint'(roll);
            if (r_mag < 0) r_mag = -r_mag;
            seen_tick  = tick;
            seen_pitch = ANGLE_WIDTH_DEF'(pitch);
            // first sample, repeated stamp or a gap: resync only, peak untouched
            if (old_tick == 0 || dt == 0 || dt > gap_max_ms)
                return ERR_CLEAR;
            if (p_mag < longint'(active_min)) begin
                rep_peak = '0;
                return ERR_CLEAR;
            end
            if (p > longint'(rep_peak)) rep_peak = ANGLE_WIDTH_DEF'(pitch);
            peak     = longint'(rep_peak);
            step_mag = p - old_p;
            if (step_mag < 0) step_mag = -step_mag;
            if (step_mag * TEMPO_SCALE > longint'(rate_max) * longint'(dt)) begin
                code = ERR_RUSHED;
            end else if (r_mag > longint'(roll_max)) begin
                code = ERR_SHRUG;
            end else if (p < peak - longint'(descent_margin)) begin
                code = (peak < longint'(peak_min)) ? ERR_RANGE_LOW : ERR_GENERAL_FORM;
                rep_peak = '0;
            end else begin
                code = ERR_GENERAL_FORM;
            end
            return code;
        endfunction

        function void note_sample(logic [TICK_W-1:0] tick,
                                  logic signed [ANGLE_IN_W-1:0] pitch,
                                  logic signed [ANGLE_IN_W-1:0] roll);
            expected_codes.push_back(classify(tick, pitch, roll));
        endfunction

        function void check_result(logic [7:0] beat);
            err_code_t         want;
            logic [CODE_W-1:0] got;
            got = beat[CODE_W-1:0];
            if (expected_codes.size() == 0) begin
                $error("error_code: result with nothing pending, expected none, actual %0d", got);
                errors++;
                return;
            end
            want = expected_codes.pop_front();
            code_hits[want]++;
            if (got !== want) begin
                $error("error_code mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // fields from bit 0 up: tick_ms[31:0], pitch_angle[46:32], roll_angle[61:47], pad
    logic [63:0]            s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // fields from bit 0 up: error_code[2:0], pad
    logic [7:0]             m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    form_scoreboard sb;

    // Stimulus side bookkeeping.
    logic [TICK_W-1:0] sample_tick = '0;
    int stim_pitch  = 0;
    int sent_count  = 0;
    int burst_left  = 0;
    bit tx_live     = 1'b0;
    bit no_gaps     = 1'b0;
    // Current limits, used only to shape stimulus.
    int cur_active  = 768;
    int cur_roll    = 1600;
    int cur_rate    = 7040;
    int cur_gap     = 200;
    // Receiver stall state; hold_ticket is bumped by the main flow to request a long hold.
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int rx_style    = 0;
    int rx_cyc      = 0;

    motion_rep_error_classifier uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int srange(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Offer one sample, hold it until the block takes the transaction, then
    // pace the sender: random bursts separated by random gaps, some gaps zero.
    task automatic send_sample(input logic [TICK_W-1:0] tick,
                               input logic signed [ANGLE_IN_W-1:0] pitch,
                               input logic signed [ANGLE_IN_W-1:0] roll);
        int gap;
        s_tvalid <= 1'b1;
        tx_live  = 1'b1;
        s_tdata  <= {2'b00, roll, pitch, tick};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(tick, pitch, roll);
        sent_count++;
        sample_tick = tick;
        stim_pitch  = int'(pitch);
        if (no_gaps) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                tx_live  = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Move the pitch to a new value. Most steps pick a time step that keeps the
    // rate legal; the rest use random steps, repeated stamps or gaps.
    task automatic step_to(input int target);
        int next, dp, dt, gap_hi, sel, roll_lim, roll_v;
        next = target;
        if (next > 11520) next = 11520;
        if (next < -11520) next = -11520;
        gap_hi = (cur_gap > 0) ? cur_gap : 50;
        dp = next - stim_pitch;
        if (dp < 0) dp = -dp;
        sel = $urandom_range(19);
        if (sel == 0) begin
            dt = 0;
        end else if (sel == 1) begin
            dt = gap_hi + 1;
        end else begin
            if (sel < 6 || cur_rate == 0)
                dt = 1 + $urandom_range(gap_hi - 1);
            else
                dt = dp * TEMPO_SCALE / cur_rate + 1 + $urandom_range(3);
            if (dt > gap_hi) dt = gap_hi;
        end
        roll_lim = (cur_roll > 11520) ? 11520 : cur_roll;
        if ($urandom_range(9) == 0)
            roll_v = srange(-11520, 11520);
        else
            roll_v = srange(-roll_lim, roll_lim);
        send_sample(sample_tick + dt, next[ANGLE_IN_W-1:0], roll_v[ANGLE_IN_W-1:0]);
    endtask

    // Stop offering and wait until every pending code has come back.
    task automatic drain_results();
        if (tx_live) begin
            s_tvalid <= 1'b0;
            tx_live  = 1'b0;
        end
        while (sb.expected_codes.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        sb.write_limit(idx, val[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ACTIVE_MIN: cur_active = val;
            CFG_ROLL_MAX:   cur_roll   = val;
            CFG_RATE_MAX:   cur_rate   = val;
            CFG_GAP_MAX_MS: cur_gap    = val;
            default: ;
        endcase
        // keep the next write's valid edge in a later time step
        @(posedge aclk);
    endtask

    task automatic set_limits(input int act, input int rll, input int rte,
                              input int pkm, input int dsc, input int gp);
        write_reg(CFG_ACTIVE_MIN, act);
        write_reg(CFG_ROLL_MAX, rll);
        write_reg(CFG_RATE_MAX, rte);
        write_reg(CFG_PEAK_MIN, pkm);
        write_reg(CFG_DESCENT_MARGIN, dsc);
        write_reg(CFG_GAP_MAX_MS, gp);
    endtask

    // Mostly whole repetitions (rest, climb to a random peak, descend back to rest)
    // with random content, mixed with noise samples and mid-run drains.
    task automatic run_random(input int n);
        int stop_at, rest_n, up_n, down_n, peak_goal, rest_goal, i, sel, dt;
        stop_at = sent_count + n;
        while (sent_count < stop_at) begin
            sel = $urandom_range(9);
            if (sel == 0) begin
                // noise: random angles with a wild time step
                case ($urandom_range(4))
                    0: dt = 0;
                    1: dt = $urandom;
                    2: dt = cur_gap;
                    3: dt = cur_gap + 1;
                    default: dt = $urandom_range(1, 40);
                endcase
                send_sample(($urandom_range(15) == 0) ? 32'd0 : sample_tick + dt,
                            ANGLE_IN_W'(srange(-11520, 11520)),
                            ANGLE_IN_W'(srange(-11520, 11520)));
            end else begin
                rest_n = $urandom_range(1, 3);
                for (i = 0; i < rest_n; i++)
                    step_to(srange(-cur_active, cur_active));
                peak_goal = $urandom_range(11520);
                if ($urandom_range(7) == 0) peak_goal = -peak_goal;
                up_n = $urandom_range(2, 10);
                for (i = 0; i < up_n; i++)
                    step_to(stim_pitch + (peak_goal - stim_pitch) / (up_n - i) + srange(-48, 48));
                rest_goal = srange(-200, 200);
                down_n = $urandom_range(2, 10);
                for (i = 0; i < down_n; i++)
                    step_to(stim_pitch + (rest_goal - stim_pitch) / (down_n - i) + srange(-48, 48));
            end
            if ($urandom_range(11) == 0) drain_results();
        end
    endtask

    // Result sink: check every accepted result transaction, then choose the next
    // ready level. The stall pattern is re-picked at random at set points of rx_cyc; a hold
    // request from the main flow forces a long stretch of ready low.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_result(m_tdata);
        rx_cyc++;
        if (rx_cyc % 64 == 0) rx_style = $urandom_range(3);
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = 150;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(1) == 1);
                2: m_tready <= ((rx_cyc % 5) > 1);
                default: m_tready <= ($urandom_range(7) != 0);
            endcase
        end
    end

    initial begin
        int p;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed samples at the reset limits.
        send_sample(32'd100,  15'sd0,      15'sd0);       // first sample after reset
        send_sample(32'd100,  15'sd900,    15'sd0);       // repeated stamp
        send_sample(32'd300,  15'sd11520,  15'sd0);       // step equal to gap limit, big jump
        send_sample(32'd301,  15'sd11520, -15'sd11520);   // roll at negative extreme
        send_sample(32'd302,  15'sd11520,  15'sd1601);    // roll just over its limit
        send_sample(32'd303,  15'sd11520,  15'sd1600);    // roll at its limit
        send_sample(32'd503, -15'sd11520,  15'sd11520);   // full swing to negative extreme
        send_sample(32'd703, -15'sd11520,  15'sd0);       // descent past a high peak
        send_sample(32'd904,  15'sd0,      15'sd0);       // step one over the gap limit
        send_sample(32'hFFFF_FFF0, 15'sd800, 15'sd0);     // huge forward jump in time
        send_sample(32'd0,    15'sd800,    15'sd0);       // wrap through zero, stores stamp 0
        send_sample(32'd10,   15'sd800,    15'sd0);       // stored stamp of zero restarts
        send_sample(32'd135,  15'sd1680,   15'sd0);       // rate exactly at its limit
        send_sample(32'd260,  15'sd2561,   15'sd0);       // rate one step over
        send_sample(32'd261,  15'sd767,    15'sd0);       // just below active limit
        send_sample(32'd262, -15'sd768,    15'sd0);       // negative pitch at active limit
        send_sample(32'd462,  15'sd600,    15'sd0);       // rest
        send_sample(32'd662,  15'sd2000,   15'sd0);       // low peak
        send_sample(32'd862,  15'sd1359,   15'sd0);       // descent after a low peak
        send_sample(32'd1062, 15'sd2700,   15'sd0);
        send_sample(32'd1262, 15'sd2880,   15'sd0);       // peak at its minimum
        send_sample(32'd1462, 15'sd2240,   15'sd0);       // exactly at descent threshold
        send_sample(32'd1662, 15'sd2239,   15'sd0);       // one past it
        run_random(120);

        for (p = 1; p < 8; p++) begin
            // Registers change only with the pipeline empty.
            drain_results();
            repeat (4) @(posedge aclk);
            case (p)
                1: set_limits($urandom_range(3000), $urandom_range(200, 4000),
                              $urandom_range(1000, 20000), $urandom_range(11520),
                              $urandom_range(3000), $urandom_range(20, 400));
                2: set_limits(0, 0, 0, 0, 0, 1);
                3: set_limits(11520, 11520, 65535, 11520, 11520, 1000);
                4: write_reg(CFG_GAP_MAX_MS, 0);   // zero gap limit: every sample resyncs
                5: set_limits($urandom_range(1500), $urandom_range(11520),
                              $urandom_range(65535), $urandom_range(11520),
                              $urandom_range(11520), $urandom_range(1, 1000));
                6: set_limits(ACTIVE_MIN_RST, ROLL_MAX_RST, RATE_MAX_RST,
                              PEAK_MIN_RST, DESCENT_MARGIN_RST, GAP_MAX_MS_RST);
                default: set_limits($urandom_range(1000), $urandom_range(500, 3000),
                                    $urandom_range(2000, 12000), $urandom_range(1000, 6000),
                                    $urandom_range(200, 1500), $urandom_range(10, 300));
            endcase
            if (p == 1) begin
                // Long receiver hold while the sender keeps offering back to back,
                // so the pipeline fills and input ready drops.
                hold_ticket <= hold_ticket + 1;
                no_gaps = 1'b1;
                repeat (30) step_to(srange(-11520, 11520));
                no_gaps = 1'b0;
                drain_results();
            end
            run_random((p == 4) ? 40 : 205);
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.expected_codes.size() != 0) begin
            $error("error_code: %0d expected results never arrived", sb.expected_codes.size());
            sb.errors++;
        end
        $display("Checked %0d samples over 8 limit settings, incl. extremes and zero gap limit.",
                 sent_count);
        $display("Codes seen: none %0d, tempo %0d, shoulder %0d, range %0d, form %0d",
                 sb.code_hits[0], sb.code_hits[1], sb.code_hits[2], sb.code_hits[3],
                 sb.code_hits[4]);
        if (sb.errors == 0) begin
            $display("[motion_rep_error_classifier] OK");
        end else begin
            $display("[motion_rep_error_classifier] ERROR");
        end
        $finish;
    end

    // Watchdog: report an error and stop if the run has not finished in time.
    initial begin
        #5_000_000;
        $display("[motion_rep_error_classifier] ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/mrec_pkg.sv
rtl/motion_rep_error_classifier.sv
sim/tb_motion_rep_error_classifier.sv
